// ----- rtl/twc_pkg.sv -----
package twc_pkg;

    localparam int SCREEN_COLUMNS = 40;
    localparam int SCREEN_ROWS    = 24;
    localparam int MEMORY_DEPTH   = 1024;
    localparam int ADDR_W         = $clog2(MEMORY_DEPTH);
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 6;

    localparam logic [7:0] BLANK_CELL = 8'hA0;
    localparam logic [7:0] HIGH_BIT   = 8'h80;
    localparam logic [7:0] NEWLINE    = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 3'd0,
        CFG_WIDTH  = 3'd1,
        CFG_TOP    = 3'd2,
        CFG_BOTTOM = 3'd3,
        CFG_COLOR  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_PUT    = 3'd0,
        OP_HOME   = 3'd1,
        OP_SETCUR = 3'd2,
        OP_RDCELL = 3'd3,
        OP_PLOT   = 3'd4,
        OP_RDPIX  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_SCROLL,
        S_DRAIN,
        S_FILL
    } t_state;

    // effective (clamped) window
    typedef struct packed {
        logic [5:0] left;
        logic [5:0] width;
        logic [4:0] top;
        logic [4:0] bottom;
        logic [3:0] color;
    } t_win;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // rows interleave in groups of eight: (row mod 8)*128 + (row/8)*40 + col
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] row,
                                                    input logic [5:0] col);
        logic [ADDR_W-1:0] a;
        a = {row[2:0], 7'd0}
            + ADDR_W'(row[4:3]) * ADDR_W'(SCREEN_COLUMNS)
            + ADDR_W'(col);
        return a;
    endfunction

endpackage

// ----- rtl/twc_ram.sv -----
module twc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-first: a read of the entry being written sees the new byte
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            o_rdata <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/twc_cfg.sv -----
module twc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [twc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [twc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output twc_pkg::t_win                  o_win
);
    import twc_pkg::*;

    logic [5:0] r_left;
    logic [5:0] r_width;
    logic [4:0] r_top;
    logic [4:0] r_bottom;
    logic [3:0] r_color;

    logic [5:0] left;
    logic [5:0] wid0;
    logic [5:0] maxw;
    logic [4:0] bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_width  <= 6'(SCREEN_COLUMNS);
            r_top    <= '0;
            r_bottom <= 5'(SCREEN_ROWS);
            r_color  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LEFT:   r_left   <= i_cfg_data;
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_TOP:    r_top    <= i_cfg_data[4:0];
                CFG_BOTTOM: r_bottom <= i_cfg_data[4:0];
                CFG_COLOR:  r_color  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        left = (r_left > 6'(SCREEN_COLUMNS - 1)) ? 6'(SCREEN_COLUMNS - 1) : r_left;
        wid0 = (r_width == '0) ? 6'd1 : r_width;
        if (r_bottom == '0) begin
            bot = 5'd1;
        end else if (r_bottom > 5'(SCREEN_ROWS)) begin
            bot = 5'(SCREEN_ROWS);
        end else begin
            bot = r_bottom;
        end
        maxw = 6'(SCREEN_COLUMNS) - left;

        o_win.left   = left;
        o_win.width  = (wid0 > maxw) ? maxw : wid0;
        o_win.bottom = bot;
        o_win.top    = (r_top >= bot) ? bot - 5'd1 : r_top;
        o_win.color  = r_color;
    end

endmodule

// ----- rtl/twc_ctrl.sv -----
module twc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  twc_pkg::t_win               i_win,
    input  logic                        i_start,
    input  logic [2:0]                  i_opcode,
    input  logic [7:0]                  i_char_code,
    input  logic [5:0]                  i_column,
    input  logic [5:0]                  i_row,
    input  logic [7:0]                  i_rdata,
    output twc_pkg::t_mem_req           o_mem,
    output logic                        o_busy,
    output logic                        o_valid,
    output logic [7:0]                  o_read_data,
    output logic [5:0]                  o_cursor_col,
    output logic [4:0]                  o_cursor_row
);
    import twc_pkg::*;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [5:0]        r_cur_col, n_cur_col;
    logic [4:0]        r_cur_row, n_cur_row;
    logic              r_nib_hi, n_nib_hi;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [5:0]        r_x, n_x;
    logic [4:0]        r_y, n_y;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_wr_pend, n_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic              r_valid, n_valid;
    logic [7:0]        r_rdata, n_rdata;

    logic              accept;
    logic [5:0]        in_col;
    logic [4:0]        in_trow;
    logic [5:0]        in_lrow;
    logic [ADDR_W-1:0] in_addr;
    logic [5:0]        win_right;
    logic [4:0]        last_row;
    logic [5:0]        col_x;
    logic              printable;
    logic [5:0]        col_inc;
    logic [5:0]        put_col;
    logic [4:0]        put_row;
    logic [4:0]        row_dec;
    t_state            sc_state;
    logic [4:0]        sc_y;
    logic              x_last;

    function automatic logic [4:0] row_y_up(input logic [4:0] y);
        return y - 5'd1;
    endfunction

    assign accept    = i_start && (r_state == S_IDLE);
    assign in_col    = (i_column > 6'(SCREEN_COLUMNS - 1)) ? 6'(SCREEN_COLUMNS - 1) : i_column;
    assign in_trow   = (i_row > 6'(SCREEN_ROWS - 1)) ? 5'(SCREEN_ROWS - 1) : i_row[4:0];
    assign in_lrow   = (i_row > 6'(2 * SCREEN_ROWS - 1)) ? 6'(2 * SCREEN_ROWS - 1) : i_row;
    assign in_addr   = (t_op'(i_opcode) == OP_RDCELL) ? cell_addr(in_trow, in_col)
                                                      : cell_addr(in_lrow[5:1], in_col);
    assign win_right = i_win.left + i_win.width;
    assign last_row  = i_win.bottom - 5'd1;
    assign col_x     = i_win.left + r_x;
    assign x_last    = (r_x == i_win.width - 6'd1);
    assign row_dec   = r_cur_row - 5'd1;

    assign printable = !i_char_code[7] && (i_char_code[6:5] != 2'b00);
    assign col_inc   = r_cur_col + 6'd1;

    always_comb begin
        put_col = r_cur_col;
        put_row = r_cur_row;
        if (printable) begin
            if (col_inc >= win_right) begin
                put_col = i_win.left;
                put_row = r_cur_row + 5'd1;
            end else begin
                put_col = col_inc;
            end
        end else if (i_char_code == NEWLINE) begin
            put_col = i_win.left;
            put_row = r_cur_row + 5'd1;
        end
    end

    // first step of one scroll pass; a one-row window only refills its row
    assign sc_state = (i_win.top == last_row) ? S_FILL : S_SCROLL;
    assign sc_y     = (i_win.top == last_row) ? last_row : i_win.top + 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_wr_pend <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_wr_pend <= n_wr_pend;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_nib_hi  <= n_nib_hi;
        r_addr    <= n_addr;
        r_x       <= n_x;
        r_y       <= n_y;
        r_wr_addr <= n_wr_addr;
        r_rdata   <= n_rdata;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_nib_hi  = r_nib_hi;
        n_addr    = r_addr;
        n_x       = r_x;
        n_y       = r_y;
        n_clr     = r_clr;
        n_wr_pend = r_wr_pend;
        n_wr_addr = r_wr_addr;
        n_valid   = 1'b0;
        n_rdata   = r_rdata;

        o_mem.we    = 1'b0;
        o_mem.waddr = r_wr_addr;
        o_mem.wdata = i_rdata;
        o_mem.raddr = in_addr;

        unique case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr;
                o_mem.wdata = '0;
                n_clr       = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(MEMORY_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op     = t_op'(i_opcode);
                    n_addr   = in_addr;
                    n_nib_hi = in_lrow[0];
                    n_x      = '0;
                    n_rdata  = '0;
                    unique case (t_op'(i_opcode))
                        OP_PUT: begin
                            o_mem.we    = printable;
                            o_mem.waddr = cell_addr(r_cur_row, r_cur_col);
                            o_mem.wdata = i_char_code | HIGH_BIT;
                            n_cur_col   = put_col;
                            n_cur_row   = put_row;
                            if (put_row >= i_win.bottom) begin
                                n_state = sc_state;
                                n_y     = sc_y;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        OP_HOME: begin
                            n_state = S_FILL;
                            n_y     = i_win.top;
                        end
                        OP_SETCUR: begin
                            n_cur_col = in_col;
                            n_cur_row = in_trow;
                            n_valid   = 1'b1;
                        end
                        OP_RDCELL, OP_PLOT, OP_RDPIX: begin
                            n_state = S_RD;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                unique case (r_op)
                    OP_PLOT: begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = r_addr;
                        o_mem.wdata = r_nib_hi ? {i_win.color, i_rdata[3:0]}
                                               : {i_rdata[7:4], i_win.color};
                        n_rdata     = '0;
                    end
                    OP_RDCELL: n_rdata = i_rdata;
                    OP_RDPIX:  n_rdata = {4'd0, r_nib_hi ? i_rdata[7:4] : i_rdata[3:0]};
                    default:   n_rdata = '0;
                endcase
            end
            S_SCROLL: begin
                // read row y while the previous beat lands one row up
                o_mem.raddr = cell_addr(r_y, col_x);
                o_mem.we    = r_wr_pend;
                n_wr_pend   = 1'b1;
                n_wr_addr   = cell_addr(row_y_up(r_y), col_x);
                if (x_last) begin
                    n_x = '0;
                    if (r_y == last_row) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_y = r_y + 5'd1;
                    end
                end else begin
                    n_x = r_x + 6'd1;
                end
            end
            S_DRAIN: begin
                o_mem.we  = 1'b1;
                n_wr_pend = 1'b0;
                n_state   = S_FILL;
                n_y       = last_row;
                n_x       = '0;
            end
            S_FILL: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = cell_addr(r_y, col_x);
                o_mem.wdata = BLANK_CELL;
                if (x_last) begin
                    n_x = '0;
                    if (r_y == last_row) begin
                        if (r_op == OP_HOME) begin
                            n_cur_col = i_win.left;
                            n_cur_row = i_win.top;
                            n_valid   = 1'b1;
                            n_state   = S_IDLE;
                        end else begin
                            n_cur_row = row_dec;
                            if (row_dec >= i_win.bottom) begin
                                n_state = sc_state;
                                n_y     = sc_y;
                            end else begin
                                n_valid = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                    end else begin
                        n_y = r_y + 5'd1;
                    end
                end else begin
                    n_x = r_x + 6'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_read_data  = r_rdata;
    assign o_cursor_col = r_cur_col;
    assign o_cursor_row = r_cur_row;

    a_idle_write_is_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && o_mem.we) |-> (i_start && t_op'(i_opcode) == OP_PUT))
        else $error("memory written while idle without a put");

    a_valid_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result beat while the sequencer is still busy");

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_cur_row <= 5'(SCREEN_ROWS - 1) && r_cur_col <= 6'(SCREEN_COLUMNS - 1)))
        else $error("cursor off screen at result");

    a_copy_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && r_wr_pend) |-> (o_mem.waddr != o_mem.raddr))
        else $error("scroll copy reads the byte it writes");

    a_drain_to_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_state == S_FILL))
        else $error("scroll copy drain not followed by bottom row fill");

endmodule

// ----- rtl/text_window_console_unit.sv -----
// Console engine over a 1024-byte text screen memory. An item is taken on a
// clock edge where start is high and busy is low; its one result comes back
// on o_valid for a single cycle and cannot be held off. Set cursor, ignored
// opcodes and a put that does not scroll finish on the accepting edge, which
// also performs the memory write, and their result follows in the next
// cycle; read cell, plot and read pixel pass through a read state, as the
// screen memory read is registered. Home fills the window with blanks, one
// byte written per cycle. A put that reaches the window bottom scrolls, each
// pass made of a copy with one read and one write per cycle, a drain and a
// refill of the bottom row (a one-row window only refills), repeated until
// the cursor is back inside the window. After reset the block clears the
// memory with busy high. Configuration writes take effect at once, so make
// them between items, while busy is low and no result is pending.
module text_window_console_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [twc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [twc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     i_opcode,
    input  logic [7:0]                     i_char_code,
    input  logic [5:0]                     i_column,
    input  logic [5:0]                     i_row,
    output logic                           o_valid,
    output logic [7:0]                     o_read_data,
    output logic [5:0]                     o_cursor_col,
    output logic [4:0]                     o_cursor_row
);
    import twc_pkg::*;

    t_win     win;
    t_mem_req mem;
    logic [7:0] rdata;

    twc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_win      (win)
    );

    twc_ram #(
        .DEPTH (MEMORY_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    twc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_win        (win),
        .i_start      (start),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_rdata      (rdata),
        .o_mem        (mem),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row)
    );

endmodule
